>>> src/mcc_pkg.sv
package mcc_pkg;

   localparam int MAX_COIN_TYPES  = 8;
   localparam int TABLE_DEPTH_DEF = 1024;

   localparam int IDX_W = 3;
   localparam int VAL_W = 10;
   localparam int CFG_W = 4;
   localparam int MIN_W = 11;

   // marker for an amount that no coin combination reaches
   localparam logic [MIN_W-1:0] UNREACHABLE = '1;

   typedef struct packed {
      logic [MIN_W-1:0] min_count;
      logic [IDX_W-1:0] last_coin;
   } entry_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_ACCEPT,
      OP_INIT,
      OP_COIN_SEL,
      OP_NEXT_COIN,
      OP_FILL,
      OP_WALK_START,
      OP_WALK_EX,
      OP_EMIT
   } op_type;

   typedef struct packed {
      logic amt_at_target;
      logic coin_skip;
      logic coin_last;
      logic tgt_zero;
      logic tgt_out;
      logic walk_end;
      logic emit_last;
   } status_type;

endpackage

>>> src/mcc_ram.sv
module mcc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

>>> src/mcc_ctrl.sv
module mcc_ctrl
   import mcc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       req_mode,
   input  status_type status,
   output logic       busy,
   output op_type     op
);

   typedef enum logic [9:0] {
      S_IDLE      = 10'b00_0000_0001,
      S_CHECK     = 10'b00_0000_0010,
      S_INIT      = 10'b00_0000_0100,
      S_COIN      = 10'b00_0000_1000,
      S_FILL      = 10'b00_0001_0000,
      S_DRAIN     = 10'b00_0010_0000,
      S_WALK_INIT = 10'b00_0100_0000,
      S_WALK_RD   = 10'b00_1000_0000,
      S_WALK_EX   = 10'b01_0000_0000,
      S_EMIT      = 10'b10_0000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      op       = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_mode) begin
                  op       = OP_ACCEPT;
                  state_in = S_CHECK;
               end else begin
                  op = OP_LOAD;
               end
            end
         end
         S_CHECK: begin
            if (status.tgt_out || status.tgt_zero) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            op = OP_INIT;
            if (status.amt_at_target) begin
               state_in = S_COIN;
            end
         end
         S_COIN: begin
            if (!status.coin_skip) begin
               op       = OP_COIN_SEL;
               state_in = S_FILL;
            end else if (status.coin_last) begin
               state_in = S_WALK_INIT;
            end else begin
               op = OP_NEXT_COIN;
            end
         end
         S_FILL: begin
            op = OP_FILL;
            if (status.amt_at_target) begin
               state_in = S_DRAIN;
            end
         end
         // let the final table write land before the next pass reads
         S_DRAIN: begin
            if (status.coin_last) begin
               state_in = S_WALK_INIT;
            end else begin
               op       = OP_NEXT_COIN;
               state_in = S_COIN;
            end
         end
         S_WALK_INIT: begin
            op       = OP_WALK_START;
            state_in = S_WALK_RD;
         end
         S_WALK_RD: begin
            state_in = S_WALK_EX;
         end
         S_WALK_EX: begin
            op       = OP_WALK_EX;
            state_in = status.walk_end ? S_EMIT : S_WALK_RD;
         end
         S_EMIT: begin
            op = OP_EMIT;
            if (status.emit_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

endmodule

>>> src/mcc_datapath.sv
module mcc_datapath
   import mcc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  op_type           op,
   input  logic [IDX_W-1:0] req_coin_index,
   input  logic [VAL_W-1:0] req_coin_value,
   input  logic [VAL_W-1:0] req_target_amount,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   output status_type       status,
   output logic             rsp_strobe,
   output logic [IDX_W-1:0] rsp_result_index,
   output logic [VAL_W-1:0] rsp_used_count,
   output logic             rsp_found,
   output logic             rsp_last_of_run
);

   localparam int AW = $clog2(TABLE_DEPTH);

   logic [CFG_W-1:0] cfg_ff;
   logic [VAL_W-1:0] denom_ff [MAX_COIN_TYPES];
   logic [VAL_W-1:0] cnt_ff   [MAX_COIN_TYPES];
   logic [VAL_W-1:0] target_ff;
   logic [VAL_W-1:0] amt_ff;
   logic [VAL_W-1:0] c_ff;
   logic [VAL_W-1:0] wr_amt_ff;
   logic [IDX_W-1:0] coin_ff;
   logic [IDX_W-1:0] emit_ff;
   logic [MIN_W-1:0] fwd_ff;
   logic             fill_vld_ff;
   logic             first_ff;
   logic             walk_first_ff;
   logic             walk_ph_ff;
   logic             found_ff;
   logic             rsp_strobe_ff;
   logic [IDX_W-1:0] rsp_index_ff;
   logic [VAL_W-1:0] rsp_count_ff;
   logic             rsp_found_ff;
   logic             rsp_last_ff;

   logic [CFG_W-1:0] n_act;
   logic [IDX_W-1:0] n_last;
   logic [IDX_W-1:0] sel_idx;
   logic [VAL_W-1:0] sel_val;
   entry_type        rd_a;
   entry_type        rd_b;
   entry_type        wr_data;
   logic             wr_en;
   logic [AW-1:0]    wr_addr;
   logic [MIN_W-1:0] prev_min;
   logic [MIN_W-1:0] fill_min;
   logic             take;
   logic [IDX_W-1:0] walk_k;
   logic             walk_fail;

   // clamp the in-use count to 1..MAX_COIN_TYPES
   always_comb begin
      if (cfg_ff == '0) begin
         n_act = CFG_W'(1);
      end else if (cfg_ff > CFG_W'(MAX_COIN_TYPES)) begin
         n_act = CFG_W'(MAX_COIN_TYPES);
      end else begin
         n_act = cfg_ff;
      end
   end
   assign n_last = IDX_W'(n_act - CFG_W'(1));

   assign walk_k  = rd_a.last_coin;
   assign sel_idx = walk_ph_ff ? walk_k : coin_ff;
   assign sel_val = denom_ff[sel_idx];

   mcc_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_addr_a (AW'(amt_ff)),
      .rd_data_a (rd_a),
      .rd_addr_b (AW'(amt_ff - c_ff)),
      .rd_data_b (rd_b)
   );

   // a unit coin reads the entry still being written: take it from the bypass
   assign prev_min = ((c_ff == VAL_W'(1)) && !first_ff) ? fwd_ff : rd_b.min_count;
   assign take     = first_ff ||
                     ((prev_min != UNREACHABLE) && ((prev_min + MIN_W'(1)) < rd_a.min_count));
   assign fill_min = !take    ? rd_a.min_count :
                     first_ff ? MIN_W'(1) : prev_min + MIN_W'(1);

   always_comb begin
      if (op == OP_INIT) begin
         wr_en             = 1'b1;
         wr_addr           = AW'(amt_ff);
         wr_data.min_count = (amt_ff == '0) ? '0 : UNREACHABLE;
         wr_data.last_coin = '0;
      end else begin
         wr_en             = fill_vld_ff && take;
         wr_addr           = AW'(wr_amt_ff);
         wr_data.min_count = fill_min;
         wr_data.last_coin = coin_ff;
      end
   end

   assign walk_fail = (walk_first_ff && (rd_a.min_count == UNREACHABLE)) ||
                      ({1'b0, walk_k} >= n_act) ||
                      (sel_val == '0) || (sel_val > amt_ff);

   assign status.amt_at_target = (amt_ff == target_ff);
   assign status.coin_skip     = (sel_val == '0) || (sel_val > target_ff);
   assign status.coin_last     = (coin_ff == n_last);
   assign status.tgt_zero      = (target_ff == '0);
   assign status.tgt_out       = (32'(target_ff) >= 32'(TABLE_DEPTH));
   assign status.walk_end      = walk_fail || (sel_val == amt_ff);
   assign status.emit_last     = (emit_ff == n_last);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_W'(1);
         fill_vld_ff   <= 1'b0;
         walk_ph_ff    <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         for (int r = 0; r < MAX_COIN_TYPES; r++) begin
            denom_ff[r] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
         if (op == OP_LOAD) begin
            denom_ff[req_coin_index] <= req_coin_value;
         end
         if (op == OP_ACCEPT) begin
            walk_ph_ff <= 1'b0;
         end else if (op == OP_WALK_START) begin
            walk_ph_ff <= 1'b1;
         end
         fill_vld_ff   <= (op == OP_FILL);
         rsp_strobe_ff <= (op == OP_EMIT);
      end
   end

   always_ff @(posedge clock) begin
      if (fill_vld_ff) begin
         fwd_ff <= fill_min;
      end
      for (int r = 0; r < MAX_COIN_TYPES; r++) begin
         if (op == OP_ACCEPT) begin
            cnt_ff[r] <= '0;
         end else if ((op == OP_WALK_EX) && !walk_fail && (walk_k == IDX_W'(r))) begin
            cnt_ff[r] <= cnt_ff[r] + VAL_W'(1);
         end
      end
      unique case (op)
         OP_ACCEPT: begin
            target_ff <= req_target_amount;
            amt_ff    <= '0;
            coin_ff   <= '0;
            emit_ff   <= '0;
            found_ff  <= (32'(req_target_amount) < 32'(TABLE_DEPTH));
         end
         OP_INIT: begin
            amt_ff <= amt_ff + VAL_W'(1);
         end
         OP_COIN_SEL: begin
            c_ff   <= sel_val;
            amt_ff <= sel_val;
         end
         OP_NEXT_COIN: begin
            coin_ff <= coin_ff + IDX_W'(1);
         end
         OP_FILL: begin
            wr_amt_ff <= amt_ff;
            first_ff  <= (amt_ff == c_ff);
            amt_ff    <= amt_ff + VAL_W'(1);
         end
         OP_WALK_START: begin
            amt_ff        <= target_ff;
            walk_first_ff <= 1'b1;
         end
         OP_WALK_EX: begin
            walk_first_ff <= 1'b0;
            if (walk_fail) begin
               found_ff <= 1'b0;
            end else begin
               amt_ff <= amt_ff - sel_val;
            end
         end
         OP_EMIT: begin
            rsp_index_ff <= emit_ff;
            rsp_count_ff <= found_ff ? cnt_ff[emit_ff] : '0;
            rsp_found_ff <= found_ff;
            rsp_last_ff  <= (emit_ff == n_last);
            emit_ff      <= emit_ff + IDX_W'(1);
         end
         default: begin
         end
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_result_index = rsp_index_ff;
   assign rsp_used_count   = rsp_count_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_last_of_run  = rsp_last_ff;

endmodule

>>> src/min_coin_change_solver_unit.sv
// Channel   Handshake               Ports
// request   start & !busy           req_mode, req_coin_index, req_coin_value,
//                                   req_target_amount
// result    rsp_strobe, one cycle   rsp_result_index, rsp_used_count, rsp_found,
//                                   rsp_last_of_run
// config    csr_wr_en               csr_wr_data (coin types in use)
//
// A load request is taken in S_IDLE and leaves busy low. A solve for target T is
// paced by the single write port of the amount table, which takes one amount a
// cycle. Results leave one per cycle and cannot be held off. Reset is synchronous
// and clears control state and the denominations and sets the register to one
// coin type; the table is rewritten by every solve before it is read.
module min_coin_change_solver_unit
   import mcc_pkg::*;
#(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic             req_mode,
   input  logic [IDX_W-1:0] req_coin_index,
   input  logic [VAL_W-1:0] req_coin_value,
   input  logic [VAL_W-1:0] req_target_amount,
   output logic             rsp_strobe,
   output logic [IDX_W-1:0] rsp_result_index,
   output logic [VAL_W-1:0] rsp_used_count,
   output logic             rsp_found,
   output logic             rsp_last_of_run,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   op_type     op;
   status_type status;

   mcc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .status   (status),
      .busy     (busy),
      .op       (op)
   );

   mcc_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .op                (op),
      .req_coin_index    (req_coin_index),
      .req_coin_value    (req_coin_value),
      .req_target_amount (req_target_amount),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .status            (status),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_index  (rsp_result_index),
      .rsp_used_count    (rsp_used_count),
      .rsp_found         (rsp_found),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   a_solve_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_mode) |=> busy)
      else $error("solve request accepted without going busy");

   a_mid_run_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_of_run) |-> busy)
      else $error("result run ended without a last marker");

   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last_of_run) |-> !busy)
      else $error("still busy after the final result");

   a_run_in_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last_of_run) |=>
         (rsp_strobe && (rsp_result_index == 3'($past(rsp_result_index) + 3'd1))))
      else $error("result run broken or out of order");

   a_unfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |-> (rsp_used_count == '0))
      else $error("count reported for an unreachable target");

endmodule

>>> test/min_coin_change_solver_unit_tb.sv
module min_coin_change_solver_unit_tb;
   import mcc_pkg::*;

   localparam logic MODE_LOAD  = 1'b0;
   localparam logic MODE_SOLVE = 1'b1;
   localparam int   NO_WAY     = 1 << 20;
   localparam int   QUIET      = 16;
   localparam int   PER_PHASE  = 25;

   typedef struct {
      logic [IDX_W-1:0] coin;
      logic [VAL_W-1:0] count;
      logic             found;
      logic             last;
   } coin_tally_type;

   class coin_change_book;
      logic [VAL_W-1:0] denom [MAX_COIN_TYPES];
      logic [CFG_W-1:0] coin_types;
      coin_tally_type   tallies_due [$];
      int mismatches, checked, solves, loads, misses;

      function new();
         coin_types = 1;
         foreach (denom[i]) denom[i] = '0;
         mismatches = 0;
         checked = 0;
         solves = 0;
         loads = 0;
         misses = 0;
      endfunction

      task report_mismatch(string what);
         $display("[%0t] MISMATCH %s", $time, what);
         mismatches++;
      endtask

      function void note_config(logic [CFG_W-1:0] value);
         coin_types = value;
      endfunction

      function int types_active();
         if (coin_types == 0) return 1;
         if (coin_types > MAX_COIN_TYPES) return MAX_COIN_TYPES;
         return coin_types;
      endfunction

      // work out the per-type tallies a request produces and queue them
      function void note_request(logic mode, logic [IDX_W-1:0] slot,
                                 logic [VAL_W-1:0] value, logic [VAL_W-1:0] target);
         int n, goal, amt, guard, k, c, prev;
         int best [TABLE_DEPTH_DEF];
         int last_coin [TABLE_DEPTH_DEF];
         logic [VAL_W-1:0] counts [MAX_COIN_TYPES];
         bit ok;
         coin_tally_type t;

         if (mode == MODE_LOAD) begin
            denom[slot] = value;
            loads++;
            return;
         end
         solves++;
         n = types_active();
         goal = target;
         foreach (counts[i]) counts[i] = '0;
         ok = (goal < TABLE_DEPTH_DEF);
         if (ok) begin
            best[0] = 0;
            last_coin[0] = 0;
            for (int j = 1; j <= goal; j++) begin
               best[j] = NO_WAY;
               last_coin[j] = 0;
            end
            for (int i = 0; i < n; i++) begin
               c = denom[i];
               if (c != 0) begin
                  for (int j = c; j <= goal; j++) begin
                     prev = best[j-c];
                     // an exact single coin always wins, so duplicates end on the later slot
                     if (j == c) begin
                        best[j] = 1;
                        last_coin[j] = i;
                     end else if (prev != NO_WAY && prev + 1 < best[j]) begin
                        best[j] = prev + 1;
                        last_coin[j] = i;
                     end
                  end
               end
            end
            ok = (best[goal] != NO_WAY);
         end
         amt = goal;
         guard = 0;
         while (ok && amt > 0 && guard < TABLE_DEPTH_DEF) begin
            k = last_coin[amt];
            c = (k < n) ? int'(denom[k]) : 0;
            if (k >= n || c == 0 || c > amt) begin
               ok = 0;
            end else begin
               counts[k] = counts[k] + 1'b1;
               amt -= c;
               guard++;
            end
         end
         if (!ok) begin
            misses++;
            foreach (counts[i]) counts[i] = '0;
         end
         for (int i = 0; i < n; i++) begin
            t.coin  = IDX_W'(i);
            t.count = counts[i];
            t.found = ok;
            t.last  = (i == n - 1);
            tallies_due.push_back(t);
         end
      endfunction

      task check_result(logic [IDX_W-1:0] coin, logic [VAL_W-1:0] count,
                        logic found, logic last);
         coin_tally_type t;

         if (tallies_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result coin=%0d count=%0d", coin, count));
            return;
         end
         t = tallies_due.pop_front();
         checked++;
         if (coin !== t.coin)
            report_mismatch($sformatf("result_index %0d, want %0d", coin, t.coin));
         if (count !== t.count)
            report_mismatch($sformatf("coin %0d used_count %0d, want %0d",
                                      t.coin, count, t.count));
         if (found !== t.found)
            report_mismatch($sformatf("coin %0d found %b, want %b", t.coin, found, t.found));
         if (last !== t.last)
            report_mismatch($sformatf("coin %0d last_of_run %b, want %b",
                                      t.coin, last, t.last));
      endtask

      task check_drained();
         foreach (tallies_due[i])
            report_mismatch($sformatf("missing result for coin %0d", tallies_due[i].coin));
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   logic             req_mode = MODE_LOAD;
   logic [IDX_W-1:0] req_coin_index = '0;
   logic [VAL_W-1:0] req_coin_value = '0;
   logic [VAL_W-1:0] req_target_amount = '0;
   logic             rsp_strobe;
   logic [IDX_W-1:0] rsp_result_index;
   logic [VAL_W-1:0] rsp_used_count;
   logic             rsp_found;
   logic             rsp_last_of_run;
   logic             csr_wr_en = 1'b0;
   logic [CFG_W-1:0] csr_wr_data = '0;

   coin_change_book book;
   int sender_idle_pct = 0;

   min_coin_change_solver_unit DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_coin_index    (req_coin_index),
      .req_coin_value    (req_coin_value),
      .req_target_amount (req_target_amount),
      .rsp_strobe        (rsp_strobe),
      .rsp_result_index  (rsp_result_index),
      .rsp_used_count    (rsp_used_count),
      .rsp_found         (rsp_found),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         book.check_result(rsp_result_index, rsp_used_count, rsp_found, rsp_last_of_run);
   end

   // called just after a rising edge; returns at the edge that took the request or after a random idle gap
   task send_request(logic mode, logic [IDX_W-1:0] slot,
                     logic [VAL_W-1:0] value, logic [VAL_W-1:0] target);
      start             <= 1'b1;
      req_mode          <= mode;
      req_coin_index    <= slot;
      req_coin_value    <= value;
      req_target_amount <= target;
      do @(posedge clock); while (busy);
      book.note_request(mode, slot, value, target);
      if ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task send_load(logic [IDX_W-1:0] slot, logic [VAL_W-1:0] value);
      send_request(MODE_LOAD, slot, value, VAL_W'($urandom));
   endtask

   task send_solve(logic [VAL_W-1:0] target);
      send_request(MODE_SOLVE, IDX_W'($urandom), VAL_W'($urandom), target);
   endtask

   task wait_idle();
      start <= 1'b0;
      while (book.tallies_due.size() != 0 || busy) @(posedge clock);
      repeat (QUIET) @(posedge clock);
   endtask

   task write_coin_types(logic [CFG_W-1:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      book.note_config(value);
      csr_wr_en <= 1'b0;
   endtask

   task random_request();
      int roll;
      int pick;

      roll = $urandom_range(99);
      pick = $urandom_range(99);
      if (roll < 35) begin
         send_load(IDX_W'($urandom_range(7)),
                   VAL_W'(pick < 10 ? 0 :
                          pick < 75 ? $urandom_range(1, 60) : $urandom_range(1, 1023)));
      end else begin
         // keep most targets small: solve time grows with the target
         send_solve(VAL_W'(pick < 90 ? $urandom_range(0, 200) :
                           pick < 97 ? $urandom_range(201, 600) :
                                       $urandom_range(601, 1023)));
      end
   endtask

   initial begin
      #100_000_000;
      $display("min_coin_change_solver_unit: mismatch");
      $finish;
   end

   initial begin
      int idle_plan [4];
      logic [CFG_W-1:0] types_plan [4];

      // the receiver cannot stall, so phases set the sender's idle share and coin types; two have a steady sender
      idle_plan  = '{0, 63, 0, 34};
      types_plan = '{4'd8, CFG_W'($urandom_range(0, 15)), 4'd15, CFG_W'($urandom_range(2, 7))};
      book = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset state: one slot, zero denomination
      send_solve(10'd0);
      send_solve(10'd7);
      send_load(3'd0, 10'd1023);
      send_solve(10'd1023);
      send_solve(10'd1022);

      write_coin_types(4'd0);
      send_load(3'd0, 10'd1);
      send_solve(10'd1023);

      write_coin_types(4'd15);
      send_load(3'd1, 10'd5);
      send_load(3'd2, 10'd10);
      send_load(3'd3, 10'd25);
      send_load(3'd4, 10'd5);
      send_load(3'd5, 10'd0);
      send_load(3'd6, 10'd2);
      send_load(3'd7, 10'd1023);
      send_solve(10'd30);
      send_solve(10'd1023);
      send_solve(10'd999);

      // even coins only: odd targets cannot be made
      write_coin_types(4'd2);
      send_load(3'd0, 10'd4);
      send_load(3'd1, 10'd6);
      send_solve(10'd9);
      send_solve(10'd10);

      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = 0;
         write_coin_types(types_plan[p]);
         sender_idle_pct = idle_plan[p];
         repeat (PER_PHASE) random_request();
      end
      sender_idle_pct = 0;
      wait_idle();
      book.check_drained();

      $display("run: %0d denomination loads, %0d solves (%0d with no change possible)",
               book.loads, book.solves, book.misses);
      $display("run: %0d per-coin results compared", book.checked);
      if (book.mismatches == 0)
         $display("min_coin_change_solver_unit: match");
      else
         $display("min_coin_change_solver_unit: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
src/mcc_pkg.sv
src/mcc_ram.sv
src/mcc_ctrl.sv
src/mcc_datapath.sv
src/min_coin_change_solver_unit.sv
test/min_coin_change_solver_unit_tb.sv
